FILE: rtl/core/klsp_pkg.sv
`default_nettype none

package klsp_pkg;

    localparam int MAX_LINE_BYTES_DEF  = 127;
    localparam int FRACTION_DIGITS_DEF = 3;

    localparam int KEY_COUNT  = 8;
    localparam int KEY_CHARS  = 11;
    localparam int NAME_POS_W = 4;
    localparam int SLOT_COUNT = 7;
    localparam int SLOT_W     = 3;
    localparam int ACC_W      = 30;
    localparam int READ_W     = 31;
    localparam int POW_W      = 20;

    localparam logic [ACC_W-1:0] MAG_LIMIT = 30'd999999999;
    localparam int TEMP_RESET_WHOLE = -100;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        PH_NAME_LEAD  = 3'd0,
        PH_NAME       = 3'd1,
        PH_NAME_TRAIL = 3'd2,
        PH_VALUE_LEAD = 3'd3,
        PH_INT        = 3'd4,
        PH_FRAC       = 3'd5
    } t_phase;

    // reading slots; the temperature slot is last
    localparam logic [SLOT_W-1:0] SLOT_DIR   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SPEED = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_GUST  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_RAIN  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_BAT   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_CAP   = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_TEMP  = 3'd6;

    // keyword text, right-justified: last character in bits [7:0]
    localparam logic [8*KEY_CHARS-1:0] KEY_TEXT [KEY_COUNT] = '{
        88'("WindDir"), 88'("WindSpeed"), 88'("WindGust"), 88'("GXTS04Temp"),
        88'("Temperature"), 88'("Rain"), 88'("BatVoltage"), 88'("CapVoltage")
    };
    localparam logic [NAME_POS_W-1:0] KEY_LEN [KEY_COUNT] = '{
        4'd7, 4'd9, 4'd8, 4'd10, 4'd11, 4'd4, 4'd10, 4'd10
    };
    localparam logic [SLOT_W-1:0] KEY_SLOT [KEY_COUNT] = '{
        SLOT_DIR, SLOT_SPEED, SLOT_GUST, SLOT_TEMP,
        SLOT_TEMP, SLOT_RAIN, SLOT_BAT, SLOT_CAP
    };

    function automatic logic [7:0] key_char(input int k, input logic [NAME_POS_W-1:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        if (pos < KEY_LEN[k]) begin
            ch = KEY_TEXT[k][8*(int'(KEY_LEN[k]) - int'(pos) - 1) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/keyvalue_line_sensor_parser_unit.sv
// Key/value line parser for a weather sensor's text stream.
// Input channel (i_valid/o_ready): one item per handshake. i_opcode = byte
// carries one received character in i_rx_byte; i_opcode = fetch asks for the
// stored readings. Lines end at newline or a zero byte; a line of 1 to
// MAX_LINE_BYTES bytes of the form "Name = number" updates one reading.
// Output channel (o_valid/i_ready): one item per fetch, carrying the new-data
// flag (then cleared) and all seven readings in units of 10^-FRACTION_DIGITS.
// Byte items produce no output item.
// An accepted item is held in the input register and parsed from it; a fetch
// result is loaded into the output register as the fetch leaves the input
// register. Throughput: one item per cycle while no fetch stalls, every item
// handled by a single pass of logic between the input and output registers.
// Stall: while a result waits in the output register a following fetch holds
// in the input register, and items behind it wait; bytes keep flowing while
// no fetch is blocked.
// Reset (synchronous, active low): empties both registers, clears the line
// parser, sets all readings to 0 except the temperature, which starts at
// -100 whole units, and clears the new-data flag.
`default_nettype none

module keyvalue_line_sensor_parser_unit #(
    parameter int MAX_LINE_BYTES  = klsp_pkg::MAX_LINE_BYTES_DEF,
    parameter int FRACTION_DIGITS = klsp_pkg::FRACTION_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_data_valid,
    output logic signed [30:0] o_wind_direction,
    output logic signed [30:0] o_wind_speed,
    output logic signed [30:0] o_wind_gust,
    output logic signed [30:0] o_air_temperature,
    output logic signed [30:0] o_rainfall,
    output logic signed [30:0] o_battery_voltage,
    output logic signed [30:0] o_capacitor_voltage
);

    localparam int LEN_W  = $clog2(MAX_LINE_BYTES + 2);
    localparam int FRAC_W = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);
    localparam int ACC_W  = klsp_pkg::ACC_W;
    localparam int RD_W   = klsp_pkg::READ_W;
    localparam int PRD_W  = ACC_W + 5;
    localparam logic [klsp_pkg::POW_W-1:0] SCALE = klsp_pkg::pow10(3'(FRACTION_DIGITS));
    localparam logic signed [RD_W-1:0] TEMP_RESET =
        RD_W'(klsp_pkg::TEMP_RESET_WHOLE * int'(SCALE));

    // input register
    logic                 r_in_valid;
    klsp_pkg::t_opcode    r_in_op;
    logic [7:0]           r_in_byte;

    // line parser state
    logic [LEN_W-1:0]                r_len, n_len;
    klsp_pkg::t_phase                r_phase, n_phase;
    logic [klsp_pkg::KEY_COUNT-1:0]  r_cand, n_cand;
    logic [klsp_pkg::NAME_POS_W-1:0] r_pos, n_pos;
    logic [ACC_W-1:0]                r_acc, n_acc;
    logic                            r_neg, n_neg;
    logic [FRAC_W-1:0]               r_fc, n_fc;
    logic                            r_ended, n_ended;

    logic signed [RD_W-1:0] r_reading [klsp_pkg::SLOT_COUNT];
    logic                   r_fresh, n_fresh;

    // output register
    logic                   r_out_valid;
    logic                   r_out_flag;
    logic signed [RD_W-1:0] r_out_rd [klsp_pkg::SLOT_COUNT];

    logic advance, out_free, do_fetch, do_byte;
    logic store_en;
    logic [klsp_pkg::SLOT_W-1:0] store_slot;
    logic signed [RD_W-1:0]      store_val;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (r_in_op == klsp_pkg::OP_BYTE || out_free);
    assign o_ready  = !r_in_valid || advance;
    assign do_fetch = advance && r_in_op == klsp_pkg::OP_FETCH;
    assign do_byte  = advance && r_in_op == klsp_pkg::OP_BYTE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_op   <= klsp_pkg::t_opcode'(i_opcode);
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        logic [7:0]       b;
        logic             digit;
        logic [3:0]       d;
        logic [PRD_W-1:0] v;
        logic [2:0]       fexp;
        logic             found;

        b     = r_in_byte;
        digit = (b >= klsp_pkg::CH_ZERO) && (b <= klsp_pkg::CH_NINE);
        d     = 4'(b - klsp_pkg::CH_ZERO);
        v     = '0;
        fexp  = '0;
        found = 1'b0;

        n_len   = r_len;
        n_phase = r_phase;
        n_cand  = r_cand;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_fc    = r_fc;
        n_ended = r_ended;
        n_fresh = r_fresh;

        store_en   = 1'b0;
        store_slot = klsp_pkg::SLOT_DIR;
        store_val  = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

        if (do_fetch) begin
            n_fresh = 1'b0;
        end else if (do_byte && (b == klsp_pkg::CH_NL || b == klsp_pkg::CH_NUL)) begin
            // finish the line: first matching keyword wins
            if (r_len != '0 && r_len <= LEN_W'(MAX_LINE_BYTES)
                    && r_phase >= klsp_pkg::PH_VALUE_LEAD) begin
                for (int k = klsp_pkg::KEY_COUNT - 1; k >= 0; k--) begin
                    if (r_cand[k]) begin
                        found      = 1'b1;
                        store_slot = klsp_pkg::KEY_SLOT[k];
                    end
                end
                store_en = found;
                if (found) n_fresh = 1'b1;
            end
            n_len   = '0;
            n_phase = klsp_pkg::PH_NAME_LEAD;
            n_cand  = '1;
            n_pos   = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_fc    = '0;
            n_ended = 1'b0;
        end else if (do_byte) begin
            if (r_len <= LEN_W'(MAX_LINE_BYTES)) n_len = r_len + 1'b1;
            unique case (r_phase)
                klsp_pkg::PH_NAME_LEAD, klsp_pkg::PH_NAME, klsp_pkg::PH_NAME_TRAIL: begin
                    if (b == klsp_pkg::CH_EQ) begin
                        // close the name: keep only keywords of this length
                        for (int k = 0; k < klsp_pkg::KEY_COUNT; k++) begin
                            if (klsp_pkg::KEY_LEN[k] != r_pos) n_cand[k] = 1'b0;
                        end
                        n_phase = klsp_pkg::PH_VALUE_LEAD;
                    end else if (klsp_pkg::is_space(b)) begin
                        if (r_phase == klsp_pkg::PH_NAME) n_phase = klsp_pkg::PH_NAME_TRAIL;
                    end else if (r_phase == klsp_pkg::PH_NAME_TRAIL) begin
                        // text after inner whitespace: nothing can match
                        n_cand  = '0;
                        n_phase = klsp_pkg::PH_NAME;
                    end else begin
                        for (int k = 0; k < klsp_pkg::KEY_COUNT; k++) begin
                            if (r_pos >= klsp_pkg::KEY_LEN[k] || klsp_pkg::key_char(k, r_pos) != b)
                                n_cand[k] = 1'b0;
                        end
                        if (r_pos != '1) n_pos = r_pos + 1'b1;
                        n_phase = klsp_pkg::PH_NAME;
                    end
                end
                klsp_pkg::PH_VALUE_LEAD, klsp_pkg::PH_INT, klsp_pkg::PH_FRAC: begin
                    if (!r_ended) begin
                        if (digit && r_phase != klsp_pkg::PH_FRAC) begin
                            v = PRD_W'(r_acc) * PRD_W'(10) + PRD_W'(d) * PRD_W'(SCALE);
                            n_acc   = (v > PRD_W'(klsp_pkg::MAG_LIMIT)) ? klsp_pkg::MAG_LIMIT
                                                                     : v[ACC_W-1:0];
                            n_phase = klsp_pkg::PH_INT;
                        end else if (digit) begin
                            if (int'(r_fc) < FRACTION_DIGITS) begin
                                n_fc = r_fc + 1'b1;
                                fexp = 3'(FRACTION_DIGITS) - 3'(r_fc) - 3'd1;
                                v = PRD_W'(r_acc) + PRD_W'(d) * PRD_W'(klsp_pkg::pow10(fexp));
                                n_acc = (v > PRD_W'(klsp_pkg::MAG_LIMIT)) ? klsp_pkg::MAG_LIMIT
                                                                         : v[ACC_W-1:0];
                            end
                        end else if (r_phase == klsp_pkg::PH_VALUE_LEAD
                                && klsp_pkg::is_space(b)) begin
                            n_ended = 1'b0;
                        end else if (r_phase == klsp_pkg::PH_VALUE_LEAD
                                && (b == klsp_pkg::CH_PLUS || b == klsp_pkg::CH_MINUS)) begin
                            n_neg   = (b == klsp_pkg::CH_MINUS);
                            n_phase = klsp_pkg::PH_INT;
                        end else if (r_phase != klsp_pkg::PH_FRAC && b == klsp_pkg::CH_POINT) begin
                            n_phase = klsp_pkg::PH_FRAC;
                        end else begin
                            n_ended = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = klsp_pkg::PH_NAME_LEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_phase <= klsp_pkg::PH_NAME_LEAD;
            r_cand  <= '1;
            r_pos   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_fc    <= '0;
            r_ended <= 1'b0;
            r_fresh <= 1'b0;
            for (int s = 0; s < klsp_pkg::SLOT_COUNT; s++) begin
                r_reading[s] <= (s == int'(klsp_pkg::SLOT_TEMP)) ? TEMP_RESET : '0;
            end
        end else begin
            r_len   <= n_len;
            r_phase <= n_phase;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_fc    <= n_fc;
            r_ended <= n_ended;
            r_fresh <= n_fresh;
            if (store_en) r_reading[store_slot] <= store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_fetch) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (do_fetch) begin
            r_out_flag <= r_fresh;
            r_out_rd   <= r_reading;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_data_valid        = r_out_flag;
    assign o_wind_direction    = r_out_rd[klsp_pkg::SLOT_DIR];
    assign o_wind_speed        = r_out_rd[klsp_pkg::SLOT_SPEED];
    assign o_wind_gust         = r_out_rd[klsp_pkg::SLOT_GUST];
    assign o_air_temperature   = r_out_rd[klsp_pkg::SLOT_TEMP];
    assign o_rainfall          = r_out_rd[klsp_pkg::SLOT_RAIN];
    assign o_battery_voltage   = r_out_rd[klsp_pkg::SLOT_BAT];
    assign o_capacitor_voltage = r_out_rd[klsp_pkg::SLOT_CAP];

    a_fetch_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_fetch |=> (o_valid && !r_fresh && o_data_valid == $past(r_fresh)))
        else $error("fetch did not hand over and clear the new-data flag");

    a_name_has_no_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == klsp_pkg::PH_NAME_LEAD || r_phase == klsp_pkg::PH_NAME
            || r_phase == klsp_pkg::PH_NAME_TRAIL) |-> (r_acc == '0 && !r_neg && r_fc == '0))
        else $error("number state set while still in the name");

    a_acc_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= klsp_pkg::MAG_LIMIT)
        else $error("accumulator above saturation limit");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LINE_BYTES + 1))
        else $error("line length counter past its saturation point");

endmodule

`default_nettype wire
